FILE: hw/rtl/lrip_pkg.sv
// shared types, constants and tables of the lidar range image projection
`default_nettype none

package lrip_pkg;

  localparam int unsigned MAX_ROWS_DEF    = 64;
  localparam int unsigned MAX_COLUMNS_DEF = 2048;

  // angle arithmetic, angles in units of 2^-32 turn
  localparam int unsigned CORDIC_STEPS = 30;
  localparam int unsigned STEP_W       = 5;
  localparam int unsigned PRESCALE     = 30;
  localparam int unsigned CR_W         = 58;
  localparam int unsigned ACC_W        = 34;
  localparam int unsigned ATAN_W       = 30;
  localparam logic signed [ACC_W-1:0] QUARTER_TURN = 34'sd1073741824;

  localparam logic [ATAN_W-1:0] ATAN_TABLE [CORDIC_STEPS] = '{
    30'h20000000, 30'h12E4051E, 30'h09FB385B, 30'h051111D4, 30'h028B0D43, 30'h0145D7E1,
    30'h00A2F61E, 30'h00517C55, 30'h0028BE53, 30'h00145F2F, 30'h000A2F98, 30'h000517CC,
    30'h00028BE6, 30'h000145F3, 30'h0000A2FA, 30'h0000517D, 30'h000028BE, 30'h0000145F,
    30'h00000A30, 30'h00000518, 30'h0000028C, 30'h00000146, 30'h000000A3, 30'h00000051,
    30'h00000029, 30'h00000014, 30'h0000000A, 30'h00000005, 30'h00000003, 30'h00000001
  };

  // distance arithmetic
  localparam int unsigned SS_W        = 50;
  localparam int unsigned SQRT_STEPS  = 25;
  localparam int unsigned RING_W      = 16;
  localparam int unsigned SQUARE_OPS  = 4;

  // occupancy memory word
  localparam int unsigned WORD_BITS  = 16;
  localparam int unsigned WORD_SHIFT = 4;

  // result status codes
  localparam logic [2:0] ST_STORED   = 3'd0;
  localparam logic [2:0] ST_ROW_OOR  = 3'd1;
  localparam logic [2:0] ST_ROW_SKIP = 3'd2;
  localparam logic [2:0] ST_CLOSE    = 3'd3;
  localparam logic [2:0] ST_TAKEN    = 3'd4;
  localparam logic [2:0] ST_CLEARED  = 3'd5;

  // register indexes
  localparam logic [1:0] CFG_ROWS    = 2'd0;
  localparam logic [1:0] CFG_COLUMNS = 2'd1;
  localparam logic [1:0] CFG_KEEP    = 2'd2;
  localparam logic [1:0] CFG_MIN_RNG = 2'd3;

  typedef struct packed {
    logic               action;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;
    logic [15:0]        ring;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  row;
    logic [10:0] column;
    logic [16:0] cell_index;
    logic [23:0] distance;
  } out_item_t;

  typedef struct packed {
    logic              load;
    logic              clr_step;
    logic              sq_step;
    logic              iter_step;
    logic [STEP_W-1:0] step;
    logic              mul_q;
    logic              col_calc;
    logic              cell_calc;
    logic              mem_read;
    logic              decide;
    logic              scan_done;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_scan;
  } ctrl_stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/lrip_datapath.sv
// datapath: registers, cordic, square root, row modulo, occupancy memory
`default_nettype none

module lrip_datapath import lrip_pkg::*; #(
  parameter int unsigned MAX_ROWS    = MAX_ROWS_DEF,
  parameter int unsigned MAX_COLUMNS = MAX_COLUMNS_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire ctrl_cmd_t  cmd_i,
  output      ctrl_stat_t stat_o,
  input  wire in_item_t   in_data_i,
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_index_i,
  input  wire logic [23:0] cfg_data_i,
  output      out_item_t  res_o
);

  localparam int unsigned CELLS   = MAX_ROWS * MAX_COLUMNS;
  localparam int unsigned WORDS   = (CELLS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned ADDR_W  = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned CELL_W  = $clog2(CELLS);
  localparam int unsigned ROWS_W  = $clog2(MAX_ROWS + 1);
  localparam int unsigned COLS_W  = $clog2(MAX_COLUMNS + 1);
  localparam int unsigned ROWI_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned COLI_W  = $clog2(MAX_COLUMNS);
  localparam int unsigned Q_W     = ACC_W + COLS_W + 2;
  localparam int unsigned K_W     = Q_W - 32;
  localparam int unsigned CW      = K_W + 2;
  localparam int unsigned LAST_SQ = (SQRT_STEPS - 1) * 2;

  // configuration
  logic [6:0]  rows_cfg_q, keep_cfg_q;
  logic [11:0] cols_cfg_q;
  logic [23:0] minr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_cfg_q <= 7'd16;
      cols_cfg_q <= 12'd1800;
      keep_cfg_q <= 7'd1;
      minr_q     <= 24'd1024;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_ROWS:    rows_cfg_q <= cfg_data_i[6:0];
        CFG_COLUMNS: cols_cfg_q <= cfg_data_i[11:0];
        CFG_KEEP:    keep_cfg_q <= cfg_data_i[6:0];
        CFG_MIN_RNG: minr_q     <= cfg_data_i;
        default:     minr_q     <= minr_q;
      endcase
    end
  end

  logic [ROWS_W-1:0] rows_eff;
  logic [COLS_W-1:0] cols_eff;
  logic [6:0]        keep_eff;

  always_comb begin
    if (32'(rows_cfg_q) > MAX_ROWS) rows_eff = ROWS_W'(MAX_ROWS);
    else                           rows_eff = ROWS_W'(rows_cfg_q);
    if (cols_cfg_q == 12'd0)                cols_eff = COLS_W'(1);
    else if (32'(cols_cfg_q) > MAX_COLUMNS) cols_eff = COLS_W'(MAX_COLUMNS);
    else                                    cols_eff = COLS_W'(cols_cfg_q);
    keep_eff = (keep_cfg_q == 7'd0) ? 7'd1 : keep_cfg_q;
  end

  // item
  in_item_t item_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) item_q <= in_data_i;
  end

  // squares, one per cycle on a shared multiplier
  logic [23:0]     ax, ay, az, sq_op;
  logic [47:0]     sq_prod;
  logic [SS_W-1:0] sumsq_q;
  logic [47:0]     lim_q;

  always_comb begin
    ax = item_q.pos_x[23] ? 24'(-item_q.pos_x) : 24'(item_q.pos_x);
    ay = item_q.pos_y[23] ? 24'(-item_q.pos_y) : 24'(item_q.pos_y);
    az = item_q.pos_z[23] ? 24'(-item_q.pos_z) : 24'(item_q.pos_z);
    case (cmd_i.step[1:0])
      2'd0:    sq_op = ax;
      2'd1:    sq_op = ay;
      2'd2:    sq_op = az;
      default: sq_op = minr_q;
    endcase
    sq_prod = {24'd0, sq_op} * {24'd0, sq_op};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sq_step) begin
      case (cmd_i.step[1:0])
        2'd0:    sumsq_q <= SS_W'(sq_prod);
        2'd3:    lim_q   <= sq_prod;
        default: sumsq_q <= sumsq_q + SS_W'(sq_prod);
      endcase
    end
  end

  // cordic: start values with a quarter-turn prerotation when y is negative
  logic signed [CR_W-1:0]  re_q, im_q, re0, im0, dr, di;
  logic signed [ACC_W-1:0] acc_q, acc0, atan_v;
  logic                    zero_q;

  always_comb begin
    re0  = CR_W'(item_q.pos_y) <<< PRESCALE;
    im0  = CR_W'(item_q.pos_x) <<< PRESCALE;
    acc0 = '0;
    if (item_q.pos_y[23]) begin
      if (!item_q.pos_x[23]) begin
        re0  = CR_W'(item_q.pos_x) <<< PRESCALE;
        im0  = -(CR_W'(item_q.pos_y) <<< PRESCALE);
        acc0 = QUARTER_TURN;
      end else begin
        re0  = -(CR_W'(item_q.pos_x) <<< PRESCALE);
        im0  = CR_W'(item_q.pos_y) <<< PRESCALE;
        acc0 = -QUARTER_TURN;
      end
    end
    dr     = im_q >>> cmd_i.step;
    di     = re_q >>> cmd_i.step;
    atan_v = $signed({{(ACC_W - ATAN_W){1'b0}}, ATAN_TABLE[cmd_i.step]});
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sq_step && cmd_i.step[1:0] == 2'd0) begin
      re_q   <= re0;
      im_q   <= im0;
      acc_q  <= acc0;
      zero_q <= (item_q.pos_x == '0) && (item_q.pos_y == '0);
    end else if (cmd_i.iter_step) begin
      if (im_q > 0) begin
        re_q  <= re_q + dr;
        im_q  <= im_q - di;
        acc_q <= acc_q + atan_v;
      end else begin
        re_q  <= re_q - dr;
        im_q  <= im_q + di;
        acc_q <= acc_q - atan_v;
      end
    end
  end

  // square root, one result bit per cycle alongside the cordic
  logic [SS_W-1:0] v_cur, r_cur, sbit, trial;
  logic [SS_W-1:0] sq_v_q, sq_res_q;

  always_comb begin
    v_cur = (cmd_i.step == '0) ? sumsq_q : sq_v_q;
    r_cur = (cmd_i.step == '0) ? '0 : sq_res_q;
    sbit  = SS_W'(1) << (6'(LAST_SQ) - {cmd_i.step, 1'b0});
    trial = r_cur + sbit;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.iter_step && 32'(cmd_i.step) < SQRT_STEPS) begin
      if (v_cur >= trial) begin
        sq_v_q   <= v_cur - trial;
        sq_res_q <= (r_cur >> 1) + sbit;
      end else begin
        sq_v_q   <= v_cur;
        sq_res_q <= r_cur >> 1;
      end
    end
  end

  // ring modulo keep, restoring, one ring bit per cycle
  logic [6:0] rem_q, rem_cur;
  logic [7:0] rem_sh;

  always_comb begin
    rem_cur = (cmd_i.step == '0) ? 7'd0 : rem_q;
    rem_sh  = {rem_cur, item_q.ring[~cmd_i.step[3:0]]};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.iter_step && 32'(cmd_i.step) < RING_W) begin
      if (rem_sh >= {1'b0, keep_eff}) rem_q <= 7'(rem_sh - {1'b0, keep_eff});
      else                           rem_q <= 7'(rem_sh);
    end
  end

  // column scaling
  logic signed [ACC_W:0]   diff;
  logic signed [Q_W-1:0]   q_q, q_mag;
  logic [K_W-1:0]          k_mag;
  logic signed [CW-1:0]    k_s, col_c, col_q;
  logic                    col_ok_q;

  always_comb begin
    diff  = (zero_q ? (ACC_W+1)'(0) : (ACC_W+1)'(acc_q)) - (ACC_W+1)'(QUARTER_TURN);
    q_mag = q_q[Q_W-1] ? -q_q : q_q;
    k_mag = K_W'((q_mag + Q_W'(64'h80000000)) >>> 32);
    k_s   = q_q[Q_W-1] ? -CW'($signed({1'b0, k_mag})) : CW'($signed({1'b0, k_mag}));
    col_c = CW'($signed({1'b0, cols_eff >> 1})) - k_s;
    if (col_c >= CW'($signed({1'b0, cols_eff}))) col_c = col_c - CW'($signed({1'b0, cols_eff}));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_q) q_q <= Q_W'(diff) * Q_W'($signed({1'b0, cols_eff}));
    if (cmd_i.col_calc) begin
      col_q    <= col_c;
      col_ok_q <= !col_c[CW-1] && (col_c < CW'($signed({1'b0, cols_eff})));
    end
  end

  // cell and drop tests
  logic [CELL_W-1:0] cell_q;
  logic              row_oor_q, skip_q, close_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.cell_calc) begin
      cell_q    <= CELL_W'(col_q[COLI_W-1:0])
                 + CELL_W'(item_q.ring[ROWI_W-1:0]) * CELL_W'(cols_eff);
      row_oor_q <= 32'(item_q.ring) >= 32'(rows_eff);
      skip_q    <= rem_q != 7'd0;
      close_q   <= sumsq_q < SS_W'(lim_q);
    end
  end

  // occupancy memory with a clearing sweep
  logic [WORD_BITS-1:0] mem [WORDS];
  logic [WORD_BITS-1:0] rd_q;
  logic [ADDR_W-1:0]    clr_addr_q, cell_addr;
  logic                 taken, store;

  assign cell_addr = ADDR_W'(cell_q >> WORD_SHIFT);
  assign taken     = rd_q[cell_q[WORD_SHIFT-1:0]];
  assign store     = cmd_i.decide && !row_oor_q && !skip_q && col_ok_q && !close_q && !taken;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_addr_q <= stat_o.clr_last ? '0 : clr_addr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step) begin
      mem[clr_addr_q] <= '0;
    end else if (store) begin
      mem[cell_addr] <= rd_q | (WORD_BITS'(1) << cell_q[WORD_SHIFT-1:0]);
    end
    if (cmd_i.mem_read) rd_q <= mem[cell_addr];
  end

  assign stat_o = '{clr_last: (32'(clr_addr_q) == WORDS - 1), is_scan: item_q.action};

  // result register
  out_item_t res_q, res_d;

  always_comb begin
    res_d = '0;
    if (cmd_i.scan_done) begin
      res_d.status = ST_CLEARED;
    end else if (row_oor_q) begin
      res_d.status = ST_ROW_OOR;
    end else if (skip_q) begin
      res_d.status = ST_ROW_SKIP;
    end else if (!col_ok_q) begin
      res_d.status = ST_ROW_OOR;
    end else begin
      res_d.status     = close_q ? ST_CLOSE : (taken ? ST_TAKEN : ST_STORED);
      res_d.row        = item_q.ring[5:0];
      res_d.column     = 11'(col_q);
      res_d.cell_index = 17'(cell_q);
      res_d.distance   = sq_res_q[23:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_done || cmd_i.decide) res_q <= res_d;
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

FILE: hw/rtl/lrip_ctrl.sv
// controller: sequences load, squares, iterations, cell lookup and clearing
`default_nettype none

module lrip_ctrl import lrip_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output      logic       in_stall_o,
  output      logic       out_valid_o,
  input  wire logic       out_stall_i,
  input  wire ctrl_stat_t stat_i,
  output      ctrl_cmd_t  cmd_o
);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_CLEAR  = 10'b0000000010,
    S_SQUARE = 10'b0000000100,
    S_ITER   = 10'b0000001000,
    S_MULQ   = 10'b0000010000,
    S_COLC   = 10'b0000100000,
    S_CELLC  = 10'b0001000000,
    S_READ   = 10'b0010000000,
    S_DECIDE = 10'b0100000000,
    S_OUT    = 10'b1000000000
  } state_e;

  state_e            state_q, state_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic              scan_q, scan_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    scan_d  = scan_q;
    cmd_o   = '0;
    cmd_o.step = cnt_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = S_SQUARE;
        end
      end
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_last) begin
          scan_d = 1'b0;
          if (scan_q) begin
            cmd_o.scan_done = 1'b1;
            state_d = S_OUT;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_SQUARE: begin
        // a scan start only clears, so it leaves here after the load
        if (stat_i.is_scan) begin
          scan_d  = 1'b1;
          state_d = S_CLEAR;
        end else begin
          cmd_o.sq_step = 1'b1;
          cnt_d = cnt_q + 1'b1;
          if (32'(cnt_q) == SQUARE_OPS - 1) begin
            cnt_d   = '0;
            state_d = S_ITER;
          end
        end
      end
      S_ITER: begin
        cmd_o.iter_step = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (32'(cnt_q) == CORDIC_STEPS - 1) state_d = S_MULQ;
      end
      S_MULQ: begin
        cmd_o.mul_q = 1'b1;
        state_d     = S_COLC;
      end
      S_COLC: begin
        cmd_o.col_calc = 1'b1;
        state_d        = S_CELLC;
      end
      S_CELLC: begin
        cmd_o.cell_calc = 1'b1;
        state_d         = S_READ;
      end
      S_READ: begin
        cmd_o.mem_read = 1'b1;
        state_d        = S_DECIDE;
      end
      S_DECIDE: begin
        cmd_o.decide = 1'b1;
        state_d      = S_OUT;
      end
      S_OUT: begin
        if (!out_stall_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      cnt_q   <= '0;
      scan_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      scan_q  <= scan_d;
    end
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = state_q == S_OUT;

endmodule

`default_nettype wire

FILE: hw/rtl/lidar_range_image_projection.sv
// top level of the lidar range image projection
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_stall_o   in_data_i   (in_item_t)
//   out      output     out_valid_o / out_stall_i out_data_o  (out_item_t)
//   cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// a point passes from transfer to result through 4 squares on one multiplier,
// 30 cordic steps (square root and row modulo run alongside), then scaling,
// cell address, memory read and decision, and the output state.
// a scan start and reset both run a clearing sweep of the occupancy memory,
// one 16-bit word a cycle, MAX_ROWS*MAX_COLUMNS/16 words (8192 by default).
// one item is in flight at a time; in_stall_o is high until the result transfers.
`default_nettype none

module lidar_range_image_projection import lrip_pkg::*; #(
  parameter int unsigned MAX_ROWS    = MAX_ROWS_DEF,
  parameter int unsigned MAX_COLUMNS = MAX_COLUMNS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output      logic        in_stall_o,
  input  wire in_item_t    in_data_i,
  output      logic        out_valid_o,
  input  wire logic        out_stall_i,
  output      out_item_t   out_data_o,
  input  wire logic        cfg_valid_i,
  output      logic        cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [23:0] cfg_data_i
);

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  assign cfg_ready_o = 1'b1;

  lrip_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  lrip_datapath #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .res_o       (out_data_o)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/lrip_checker.sv
// port-level checks of the lidar range image projection, bound to the top level
`default_nettype none

module lrip_checker import lrip_pkg::*; (
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_stall_o,
  input wire logic      out_valid_o,
  input wire logic      out_stall_i,
  input wire out_item_t out_data_o
);

  // a held result does not move
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // one item in flight: a transfer closes the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input open after transfer");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input open while result waits");

  // dropped rows and scan starts carry no coordinates
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == ST_CLEARED || out_data_o.status == ST_ROW_OOR
      || out_data_o.status == ST_ROW_SKIP)
    |-> out_data_o.row == '0 && out_data_o.column == '0
      && out_data_o.cell_index == '0 && out_data_o.distance == '0)
    else $error("nonzero fields on a dropped row");

endmodule

bind lidar_range_image_projection lrip_checker u_lrip_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
